FILE: design/gnns_pkg.sv
// Shared types, constants and codes for the grid nearest-neighbour search core.
// No dependencies; gnns_div and the core refer to it by scoped names.
`default_nettype none

package gnns_pkg;

  // Default sizing of the grid and entity tables
  localparam int MAX_CELLS_PER_SIDE_DEF = 16;
  localparam int CELL_CAPACITY_DEF      = 16;
  localparam int MAX_ENTITIES_DEF       = 256;

  // Fixed field widths
  localparam int POS_W  = 17;  // signed position, 4 fraction bits
  localparam int RAD_W  = 16;
  localparam int SIDE_W = 16;
  localparam int CPS_W  = 5;
  localparam int ID_W   = 8;
  localparam int DIST_W = 34;
  localparam int DIVD_W = 19;  // signed dividend (pos +/- radius - origin)
  localparam int MAG_W  = DIVD_W - 1;
  localparam int CELL_W = 20;  // signed cell coordinate for clamping
  localparam int MUL_W  = 18;
  localparam int SQ_W   = 2 * MUL_W;
  localparam int R2_W   = 2 * RAD_W;
  localparam int CFG_W  = 17;

  localparam logic signed [POS_W-1:0] ORIGIN_RST    = -17'sd320;
  localparam logic [SIDE_W-1:0]       CELL_SIDE_RST = 16'd3232;
  localparam logic [CPS_W-1:0]        CPS_RST       = 5'd10;

  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_QUERY  = 2'd2,
    REQ_NONE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    STS_OK      = 2'd0,
    STS_DEAD    = 2'd1,
    STS_OUTSIDE = 2'd2,
    STS_FULL    = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_ORIGIN_X       = 2'd0,
    CFG_ORIGIN_Y       = 2'd1,
    CFG_CELL_SIDE      = 2'd2,
    CFG_CELLS_PER_SIDE = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_INS_CHK,
    ST_INS_RD,
    ST_INS_WR,
    ST_Q_R2,
    ST_Q_INIT,
    ST_Q_CELL,
    ST_Q_FILL,
    ST_Q_SLOT,
    ST_Q_POS,
    ST_Q_MX,
    ST_Q_MY,
    ST_Q_CMP,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

endpackage

`default_nettype wire

FILE: design/gnns_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`default_nettype none

module gnns_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] waddr,
  input  wire logic [W-1:0]                  wdata,
  input  wire logic [(D > 1 ? $clog2(D) : 1)-1:0] raddr,
  output logic      [W-1:0]                  rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

FILE: design/gnns_div.sv
// Iterative restoring divider, one quotient bit a cycle, truncating toward zero.
// Depends on gnns_pkg.
`default_nettype none

module gnns_div (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  input  wire logic                                 start,
  input  wire logic signed [gnns_pkg::DIVD_W-1:0]   dividend,
  input  wire logic        [gnns_pkg::SIDE_W-1:0]   divisor,
  output gnns_pkg::div_sts_t                        sts,
  output logic signed      [gnns_pkg::DIVD_W-1:0]   quot
);

  localparam int MW = gnns_pkg::MAG_W;
  localparam int SW = gnns_pkg::SIDE_W;

  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic          neg_r, neg_nxt;
  logic [MW-1:0] q_r, q_nxt;
  logic [SW-1:0] rem_r, rem_nxt;
  logic [SW:0]   rem_sh;
  logic signed [gnns_pkg::DIVD_W-1:0] mag;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    neg_nxt  = neg_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    mag      = (dividend < 0) ? -dividend : dividend;
    rem_sh   = {rem_r, q_r[MW-1]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      neg_nxt  = dividend < 0;
      q_nxt    = mag[MW-1:0];
      rem_nxt  = '0;
    end else if (busy_r) begin
      // shift in the next dividend bit and subtract where it fits
      if (rem_sh >= {1'b0, divisor}) begin
        rem_nxt = SW'(rem_sh - {1'b0, divisor});
        q_nxt   = {q_r[MW-2:0], 1'b1};
      end else begin
        rem_nxt = rem_sh[SW-1:0];
        q_nxt   = {q_r[MW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 5'd1;
      if (cnt_r == 5'(MW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    neg_r <= neg_nxt;
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quot = neg_r ? -$signed({1'b0, q_r}) : $signed({1'b0, q_r});

`ifndef SYNTHESIS
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a running division");
`endif

endmodule

`default_nettype wire

FILE: design/grid_nearest_neighbor_search_core.sv
// Uniform-grid store with fixed-radius nearest-neighbour query.
// Depends on gnns_pkg, gnns_ram and gnns_div.
//
// Use: one request word enters on in_* (valid/stall); one result word leaves
// on out_* for every request. Requests: clear empties every cell by dropping
// all fill-valid bits, insert bins an entity by (pos - origin) / cell_side,
// query scans the cells around its centre and returns the nearest stored
// entity within radius other than its own id or one at its exact position.
// The block takes one request at a time; in_stall is high while it works.
// Clear, unused code and dead insert go straight to the result; insert runs
// two divisions, then reads the cell fill and writes the tables unless it is
// outside or the cell is full; query runs four divisions and squares the
// radius, then visits each cell, reads its slots, fetches positions and
// evaluates each distance. The shared bit-serial divider (18 quotient bits
// a division) and the slot-by-slot walk through the cell tables set the pace.
// A finished result is held in the output register; a new request is taken
// while it waits, and the next result waits in its final state until the
// receiver drops out_stall.
// Reset (synchronous, rst_n low) empties the grid, restores the default
// configuration and drops any pending result. Configuration is written on
// cfg_we by register index; write it only while the block is idle.
`default_nettype none

module grid_nearest_neighbor_search_core #(
  parameter int MAX_CELLS_PER_SIDE = gnns_pkg::MAX_CELLS_PER_SIDE_DEF,
  parameter int CELL_CAPACITY      = gnns_pkg::CELL_CAPACITY_DEF,
  parameter int MAX_ENTITIES       = gnns_pkg::MAX_ENTITIES_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire logic [1:0]                         in_req_type,
  input  wire logic [gnns_pkg::ID_W-1:0]          in_entity_id,
  input  wire logic signed [gnns_pkg::POS_W-1:0]  in_pos_x,
  input  wire logic signed [gnns_pkg::POS_W-1:0]  in_pos_y,
  input  wire logic                               in_alive,
  input  wire logic [gnns_pkg::RAD_W-1:0]         in_radius,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output logic                                    out_found,
  output logic [gnns_pkg::ID_W-1:0]               out_nearest_id,
  output logic [gnns_pkg::DIST_W-1:0]             out_nearest_dist_sq,
  output logic [1:0]                              out_status,
  input  wire logic                               cfg_we,
  input  wire logic [1:0]                         cfg_idx,
  input  wire logic [gnns_pkg::CFG_W-1:0]         cfg_wdata
);

  localparam int POS_W  = gnns_pkg::POS_W;
  localparam int CELL_W = gnns_pkg::CELL_W;
  localparam int MUL_W  = gnns_pkg::MUL_W;
  localparam int SQ_W   = gnns_pkg::SQ_W;
  localparam int R2_W   = gnns_pkg::R2_W;
  localparam int DIST_W = gnns_pkg::DIST_W;
  localparam int ID_W   = gnns_pkg::ID_W;
  localparam int DIVD_W = gnns_pkg::DIVD_W;
  localparam int NUM_CELLS = MAX_CELLS_PER_SIDE * MAX_CELLS_PER_SIDE;
  localparam int NUM_SLOTS = NUM_CELLS * CELL_CAPACITY;
  localparam int CAW = (NUM_CELLS > 1) ? $clog2(NUM_CELLS) : 1;
  localparam int SAW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int EAW = (MAX_ENTITIES > 1) ? $clog2(MAX_ENTITIES) : 1;
  localparam int CW  = (MAX_CELLS_PER_SIDE > 1) ? $clog2(MAX_CELLS_PER_SIDE) : 1;
  localparam int NW  = $clog2(MAX_CELLS_PER_SIDE + 1);
  localparam int FW  = $clog2(CELL_CAPACITY + 1);

  gnns_pkg::state_t state_r, state_nxt;

  // configuration
  logic signed [POS_W-1:0]            org_x_r, org_y_r;
  logic [gnns_pkg::SIDE_W-1:0]        side_r;
  logic [gnns_pkg::CPS_W-1:0]         cps_r;

  // request held for the whole operation
  gnns_pkg::req_t                     req_r;
  logic [ID_W-1:0]                    id_r;
  logic signed [POS_W-1:0]            px_r, py_r;
  logic [gnns_pkg::RAD_W-1:0]         r_r;
  logic                               load_in;

  // division sequencing
  logic [1:0]                         sel_r, sel_nxt;
  logic signed [DIVD_W-1:0]           q_r [4];
  logic                               div_start;
  logic signed [DIVD_W-1:0]           dividend;
  logic signed [DIVD_W-1:0]           div_quot;
  gnns_pkg::div_sts_t                 div_sts;
  logic                               div_last;

  // scan state
  logic [CW-1:0]  x_r, x_nxt, y_r, y_nxt, x_lo_r, x_lo_nxt, x_hi_r, x_hi_nxt, y_hi_r, y_hi_nxt;
  logic [FW-1:0]  k_r, k_nxt, fill_r, fill_nxt;
  logic [ID_W-1:0] cand_r, cand_nxt;
  logic signed [MUL_W-1:0] dx_r, dx_nxt, dy_r, dy_nxt, mul_a;
  logic signed [SQ_W-1:0]  prod_r;
  logic [SQ_W-2:0]         acc_r, acc_nxt;
  logic [SQ_W-1:0]         d2;
  logic [R2_W-1:0]         r2_r, r2_nxt;
  logic                    adv_k, adv_cell;

  // result under construction
  logic                    found_r, found_nxt;
  logic [ID_W-1:0]         best_id_r, best_id_nxt;
  logic [DIST_W-1:0]       best_d_r, best_d_nxt;
  gnns_pkg::status_t       status_r, status_nxt;

  // output register
  logic                    out_valid_r, out_load;
  logic                    out_found_r;
  logic [ID_W-1:0]         out_id_r;
  logic [DIST_W-1:0]       out_d_r;
  gnns_pkg::status_t       out_status_r;

  // tables
  logic [NUM_CELLS-1:0]    fill_vld_r;
  logic                    vld_set, vld_clr;
  logic [CAW-1:0]          cell_addr;
  logic [FW-1:0]           fill_rdata, fill_now;
  logic                    fill_we;
  logic [SAW-1:0]          slot_waddr, slot_raddr;
  logic [ID_W-1:0]         slot_rdata;
  logic                    slot_we, pos_we;
  logic [2*POS_W-1:0]      pos_rdata;
  logic signed [POS_W-1:0] ent_x, ent_y;

  // derived configuration and clamp terms
  logic [gnns_pkg::SIDE_W-1:0] side_eff;
  logic [NW-1:0]               n_eff;
  logic signed [CELL_W-1:0]    n_m1;
  logic signed [CELL_W-1:0]    qe0, qe1, qe2, qe3;
  logic signed [CELL_W-1:0]    sx_c, ex_c, sy_c, ey_c;
  logic                        axis_y, off_add, off_sub;
  logic signed [DIVD_W-1:0]    off, pos_sel_e, org_sel_e;

  assign side_eff = (side_r == '0) ? gnns_pkg::SIDE_W'(1) : side_r;
  assign n_eff = (32'(cps_r) > MAX_CELLS_PER_SIDE) ? NW'(MAX_CELLS_PER_SIDE) : NW'(cps_r);
  assign n_m1  = $signed(CELL_W'(n_eff)) - CELL_W'(1);

  // dividend: insert uses x then y; query uses x-r, x+r, y-r, y+r
  assign axis_y    = (req_r == gnns_pkg::REQ_INSERT) ? sel_r[0] : sel_r[1];
  assign off_add   = (req_r == gnns_pkg::REQ_QUERY) && sel_r[0];
  assign off_sub   = (req_r == gnns_pkg::REQ_QUERY) && !sel_r[0];
  assign off       = off_add ? $signed(DIVD_W'(r_r)) :
                     off_sub ? -$signed(DIVD_W'(r_r)) : '0;
  assign pos_sel_e = axis_y ? DIVD_W'(py_r) : DIVD_W'(px_r);
  assign org_sel_e = axis_y ? DIVD_W'(org_y_r) : DIVD_W'(org_x_r);
  assign dividend  = pos_sel_e + off - org_sel_e;
  assign div_last  = (req_r == gnns_pkg::REQ_INSERT) ? (sel_r == 2'd1) : (sel_r == 2'd3);

  assign qe0 = CELL_W'(q_r[0]);
  assign qe1 = CELL_W'(q_r[1]);
  assign qe2 = CELL_W'(q_r[2]);
  assign qe3 = CELL_W'(q_r[3]);
  assign sx_c = (qe0 < 0) ? '0 : qe0;
  assign ex_c = (qe1 > n_m1) ? n_m1 : qe1;
  assign sy_c = (qe2 < 0) ? '0 : qe2;
  assign ey_c = (qe3 > n_m1) ? n_m1 : qe3;

  assign cell_addr  = CAW'(32'(y_r) * MAX_CELLS_PER_SIDE + 32'(x_r));
  assign fill_now   = fill_vld_r[cell_addr] ? fill_rdata : '0;
  assign slot_waddr = SAW'(32'(cell_addr) * CELL_CAPACITY + 32'(fill_now));
  assign ent_x      = pos_rdata[2*POS_W-1:POS_W];
  assign ent_y      = pos_rdata[POS_W-1:0];
  assign d2         = SQ_W'(acc_r) + SQ_W'(prod_r);

  gnns_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (side_eff),
    .sts      (div_sts),
    .quot     (div_quot)
  );

  gnns_ram #(.W(FW), .D(NUM_CELLS)) u_fill_ram (
    .clk   (clk),
    .we    (fill_we),
    .waddr (cell_addr),
    .wdata (FW'(fill_now + FW'(1))),
    .raddr (cell_addr),
    .rdata (fill_rdata)
  );

  gnns_ram #(.W(ID_W), .D(NUM_SLOTS)) u_slot_ram (
    .clk   (clk),
    .we    (slot_we),
    .waddr (slot_waddr),
    .wdata (id_r),
    .raddr (slot_raddr),
    .rdata (slot_rdata)
  );

  gnns_ram #(.W(2*POS_W), .D(MAX_ENTITIES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (EAW'(id_r)),
    .wdata ({px_r, py_r}),
    .raddr (EAW'(slot_rdata)),
    .rdata (pos_rdata)
  );

  // sequencer
  always_comb begin
    state_nxt   = state_r;
    sel_nxt     = sel_r;
    x_nxt       = x_r;
    y_nxt       = y_r;
    x_lo_nxt    = x_lo_r;
    x_hi_nxt    = x_hi_r;
    y_hi_nxt    = y_hi_r;
    k_nxt       = k_r;
    fill_nxt    = fill_r;
    cand_nxt    = cand_r;
    dx_nxt      = dx_r;
    dy_nxt      = dy_r;
    acc_nxt     = acc_r;
    r2_nxt      = r2_r;
    found_nxt   = found_r;
    best_id_nxt = best_id_r;
    best_d_nxt  = best_d_r;
    status_nxt  = status_r;
    mul_a       = '0;
    div_start   = 1'b0;
    fill_we     = 1'b0;
    slot_we     = 1'b0;
    pos_we      = 1'b0;
    vld_set     = 1'b0;
    vld_clr     = 1'b0;
    load_in     = 1'b0;
    out_load    = 1'b0;
    adv_k       = 1'b0;
    adv_cell    = 1'b0;

    unique case (state_r)
      gnns_pkg::ST_IDLE: begin
        if (in_valid) begin
          load_in     = 1'b1;
          found_nxt   = 1'b0;
          best_id_nxt = '0;
          best_d_nxt  = '0;
          status_nxt  = gnns_pkg::STS_OK;
          sel_nxt     = '0;
          unique case (gnns_pkg::req_t'(in_req_type))
            gnns_pkg::REQ_CLEAR: begin
              vld_clr   = 1'b1;
              state_nxt = gnns_pkg::ST_DONE;
            end
            gnns_pkg::REQ_INSERT: begin
              if (!in_alive) begin
                status_nxt = gnns_pkg::STS_DEAD;
                state_nxt  = gnns_pkg::ST_DONE;
              end else begin
                state_nxt = gnns_pkg::ST_DIV_GO;
              end
            end
            gnns_pkg::REQ_QUERY: state_nxt = gnns_pkg::ST_DIV_GO;
            gnns_pkg::REQ_NONE:  state_nxt = gnns_pkg::ST_DONE;
          endcase
        end
      end
      gnns_pkg::ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = gnns_pkg::ST_DIV_WAIT;
      end
      gnns_pkg::ST_DIV_WAIT: begin
        if (div_sts.done) begin
          if (div_last) begin
            state_nxt = (req_r == gnns_pkg::REQ_INSERT) ? gnns_pkg::ST_INS_CHK
                                                         : gnns_pkg::ST_Q_R2;
          end else begin
            sel_nxt   = sel_r + 2'd1;
            state_nxt = gnns_pkg::ST_DIV_GO;
          end
        end
      end
      gnns_pkg::ST_INS_CHK: begin
        if (32'(id_r) >= MAX_ENTITIES || qe0 < 0 || qe0 > n_m1 || qe1 < 0 || qe1 > n_m1) begin
          status_nxt = gnns_pkg::STS_OUTSIDE;
          state_nxt  = gnns_pkg::ST_DONE;
        end else begin
          x_nxt     = qe0[CW-1:0];
          y_nxt     = qe1[CW-1:0];
          state_nxt = gnns_pkg::ST_INS_RD;
        end
      end
      gnns_pkg::ST_INS_RD: state_nxt = gnns_pkg::ST_INS_WR;
      gnns_pkg::ST_INS_WR: begin
        if (fill_now >= FW'(CELL_CAPACITY)) begin
          status_nxt = gnns_pkg::STS_FULL;
        end else begin
          fill_we = 1'b1;
          slot_we = 1'b1;
          pos_we  = 1'b1;
          vld_set = 1'b1;
        end
        state_nxt = gnns_pkg::ST_DONE;
      end
      gnns_pkg::ST_Q_R2: begin
        mul_a     = $signed(MUL_W'(r_r));
        state_nxt = gnns_pkg::ST_Q_INIT;
      end
      gnns_pkg::ST_Q_INIT: begin
        r2_nxt = prod_r[R2_W-1:0];
        if (sx_c > ex_c || sy_c > ey_c) begin
          state_nxt = gnns_pkg::ST_DONE;
        end else begin
          x_nxt     = sx_c[CW-1:0];
          y_nxt     = sy_c[CW-1:0];
          x_lo_nxt  = sx_c[CW-1:0];
          x_hi_nxt  = ex_c[CW-1:0];
          y_hi_nxt  = ey_c[CW-1:0];
          state_nxt = gnns_pkg::ST_Q_CELL;
        end
      end
      gnns_pkg::ST_Q_CELL: state_nxt = gnns_pkg::ST_Q_FILL;
      gnns_pkg::ST_Q_FILL: begin
        if (fill_now == '0) begin
          adv_cell = 1'b1;
        end else begin
          fill_nxt  = fill_now;
          k_nxt     = '0;
          state_nxt = gnns_pkg::ST_Q_SLOT;
        end
      end
      gnns_pkg::ST_Q_SLOT: begin
        if (slot_rdata == id_r || 32'(slot_rdata) >= MAX_ENTITIES) begin
          adv_k = 1'b1;
        end else begin
          cand_nxt  = slot_rdata;
          state_nxt = gnns_pkg::ST_Q_POS;
        end
      end
      gnns_pkg::ST_Q_POS: begin
        dx_nxt = MUL_W'(ent_x) - MUL_W'(px_r);
        dy_nxt = MUL_W'(ent_y) - MUL_W'(py_r);
        if (ent_x == px_r && ent_y == py_r) begin
          adv_k = 1'b1;
        end else begin
          state_nxt = gnns_pkg::ST_Q_MX;
        end
      end
      gnns_pkg::ST_Q_MX: begin
        mul_a     = dx_r;
        state_nxt = gnns_pkg::ST_Q_MY;
      end
      gnns_pkg::ST_Q_MY: begin
        mul_a     = dy_r;
        acc_nxt   = prod_r[SQ_W-2:0];
        state_nxt = gnns_pkg::ST_Q_CMP;
      end
      gnns_pkg::ST_Q_CMP: begin
        // strict less keeps the first candidate on ties
        if (d2 <= SQ_W'(r2_r) && (!found_r || d2 < SQ_W'(best_d_r))) begin
          found_nxt   = 1'b1;
          best_id_nxt = cand_r;
          best_d_nxt  = DIST_W'(d2);
        end
        adv_k = 1'b1;
      end
      gnns_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = gnns_pkg::ST_IDLE;
        end
      end
    endcase

    // advance to the next slot, then the next cell in row-major order
    if (adv_k) begin
      if (FW'(k_r + FW'(1)) < fill_r) begin
        k_nxt     = FW'(k_r + FW'(1));
        state_nxt = gnns_pkg::ST_Q_SLOT;
      end else begin
        adv_cell = 1'b1;
      end
    end
    if (adv_cell) begin
      if (x_r < x_hi_r) begin
        x_nxt     = CW'(x_r + CW'(1));
        state_nxt = gnns_pkg::ST_Q_CELL;
      end else if (y_r < y_hi_r) begin
        y_nxt     = CW'(y_r + CW'(1));
        x_nxt     = x_lo_r;
        state_nxt = gnns_pkg::ST_Q_CELL;
      end else begin
        state_nxt = gnns_pkg::ST_DONE;
      end
    end

    slot_raddr = SAW'(32'(cell_addr) * CELL_CAPACITY + 32'(k_nxt));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= gnns_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      fill_vld_r  <= '0;
      org_x_r     <= gnns_pkg::ORIGIN_RST;
      org_y_r     <= gnns_pkg::ORIGIN_RST;
      side_r      <= gnns_pkg::CELL_SIDE_RST;
      cps_r       <= gnns_pkg::CPS_RST;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (vld_clr) begin
        fill_vld_r <= '0;
      end else if (vld_set) begin
        fill_vld_r[cell_addr] <= 1'b1;
      end
      if (cfg_we) begin
        unique case (gnns_pkg::cfg_idx_t'(cfg_idx))
          gnns_pkg::CFG_ORIGIN_X:       org_x_r <= $signed(cfg_wdata[POS_W-1:0]);
          gnns_pkg::CFG_ORIGIN_Y:       org_y_r <= $signed(cfg_wdata[POS_W-1:0]);
          gnns_pkg::CFG_CELL_SIDE:      side_r  <= cfg_wdata[gnns_pkg::SIDE_W-1:0];
          gnns_pkg::CFG_CELLS_PER_SIDE: cps_r   <= cfg_wdata[gnns_pkg::CPS_W-1:0];
        endcase
      end
    end

    if (load_in) begin
      req_r <= gnns_pkg::req_t'(in_req_type);
      id_r  <= in_entity_id;
      px_r  <= in_pos_x;
      py_r  <= in_pos_y;
      r_r   <= in_radius;
    end
    if (state_r == gnns_pkg::ST_DIV_WAIT && div_sts.done) begin
      q_r[sel_r] <= div_quot;
    end
    sel_r     <= sel_nxt;
    x_r       <= x_nxt;
    y_r       <= y_nxt;
    x_lo_r    <= x_lo_nxt;
    x_hi_r    <= x_hi_nxt;
    y_hi_r    <= y_hi_nxt;
    k_r       <= k_nxt;
    fill_r    <= fill_nxt;
    cand_r    <= cand_nxt;
    dx_r      <= dx_nxt;
    dy_r      <= dy_nxt;
    acc_r     <= acc_nxt;
    r2_r      <= r2_nxt;
    prod_r    <= mul_a * mul_a;
    found_r   <= found_nxt;
    best_id_r <= best_id_nxt;
    best_d_r  <= best_d_nxt;
    status_r  <= status_nxt;
    if (out_load) begin
      out_found_r  <= found_r;
      out_id_r     <= best_id_r;
      out_d_r      <= best_d_r;
      out_status_r <= status_r;
    end
  end

  assign in_stall            = (state_r != gnns_pkg::ST_IDLE);
  assign out_valid           = out_valid_r;
  assign out_found           = out_found_r;
  assign out_nearest_id      = out_id_r;
  assign out_nearest_dist_sq = out_d_r;
  assign out_status          = out_status_r;

`ifndef SYNTHESIS
  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r != gnns_pkg::ST_IDLE)
    else $error("accepted word did not start an operation");
  a_found_status_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> out_status == gnns_pkg::STS_OK)
    else $error("neighbour reported with non-ok status");
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_found |-> out_nearest_id == '0 && out_nearest_dist_sq == '0)
    else $error("empty result carries id or distance");
  a_scan_in_window: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == gnns_pkg::ST_Q_CELL |-> x_r <= x_hi_r && y_r <= y_hi_r && x_r >= x_lo_r)
    else $error("scan left the query window");
  a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_sts.busy)
    else $error("division started while divider busy");
`endif

endmodule

`default_nettype wire
